[design/sba_pkg.sv]
// Shared types and constants for the sector bitmap allocator.
// Holds the transaction structs, sequencer states and default sizes.
// No dependencies; every other design file refers to it by scoped names.
package sba_pkg;

  // Sizes fixed by the payload and register formats.
  localparam int WORD_BITS     = 32;
  localparam int CFG_W         = 17;
  localparam int CNT_W         = 7;
  localparam int SECTOR_W      = 16;
  localparam int TOTAL_W       = 17;
  localparam int SECTORS_DEF   = 65536;
  localparam int MAX_BATCH_DEF = 64;
  localparam logic [CFG_W-1:0] SIU_RESET = 17'd65536;

  // Operation codes of an input transaction.
  localparam logic OP_RELEASE  = 1'b0;
  localparam logic OP_ALLOCATE = 1'b1;

  // Input transaction.
  typedef struct packed {
    logic                op;
    logic [SECTOR_W-1:0] sector;
    logic [CNT_W-1:0]    count;
  } in_t;

  // Result transaction.
  typedef struct packed {
    logic [SECTOR_W-1:0] granted_sector;
    logic                granted;
    logic                last;
    logic                rejected;
    logic [TOTAL_W-1:0]  free_total;
  } out_t;

  // Status of the lowest-set-bit search.
  typedef struct packed {
    logic                 found;
    logic [4:0]           idx;
    logic [WORD_BITS-1:0] low;
  } ff_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RUPD,
    ST_ALOAD,
    ST_AGRANT,
    ST_AWB,
    ST_FINAL
  } state_t;

endpackage

[design/sba_map_ram.sv]
// Free bitmap storage: one 32-bit word per group of 32 sectors.
// One write port and one read port, read data registered.
// Depends on sba_pkg for the word width.
module sba_map_ram #(
  parameter int DEPTH = 2048,
  parameter int AW    = 11
) (
  input  logic                          clk,
  input  logic                          we,
  input  logic [AW-1:0]                 waddr,
  input  logic [sba_pkg::WORD_BITS-1:0] wdata,
  input  logic                          re,
  input  logic [AW-1:0]                 raddr,
  output logic [sba_pkg::WORD_BITS-1:0] rdata
);

  logic [sba_pkg::WORD_BITS-1:0] mem [DEPTH];
  logic [sba_pkg::WORD_BITS-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; the data holds until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[design/sba_find_first.sv]
// Lowest-set-bit search over one bitmap word.
// Isolates the lowest set bit and encodes its position.
// Depends on sba_pkg for the word width and the result struct.
module sba_find_first (
  input  logic [sba_pkg::WORD_BITS-1:0] word,
  output sba_pkg::ff_t                  res
);

  logic [sba_pkg::WORD_BITS-1:0] low;
  logic [4:0]                    idx;

  // Two's complement trick keeps only the lowest set bit.
  assign low = word & (~word + 32'd1);

  // Encode the one-hot position.
  always_comb begin
    idx = '0;
    for (int j = 0; j < sba_pkg::WORD_BITS; j++) begin
      if (low[j]) begin
        idx = idx | 5'(j);
      end
    end
  end

  assign res.found = |word;
  assign res.idx   = idx;
  assign res.low   = low;

endmodule

[design/sector_bitmap_allocator_core.sv]
// Sector bitmap allocator: top level with the sequencer and result register.
// Depends on sba_pkg, sba_map_ram and sba_find_first.
//
// Usage: the input channel (in_valid/in_ready/in_data) takes one transaction
// at a time. A release marks one sector free and returns one result. An
// allocate scans the bitmap from sector 0 upward, one 32-bit word per cycle
// while the words hold no free sector in range, and returns one result per
// granted sector (the final one marked last), or a single result with granted low if nothing is granted.
// cfg_we/cfg_wdata set the number of sectors covered; write only when idle.
// A release reads the bitmap word, sets the bit of the sector and writes the
// word back before its result is registered; a rejected release goes straight
// to its result. An allocate fetches words through the single read port of the
// bitmap memory, takes one grant at a time from a word with free sectors, and
// writes back each word that yields grants.
// After reset the bitmap is cleared word by word (2048 words at the default
// size), during which in_ready stays low; config writes still work.
// Results sit in an output register; a new transaction is accepted while a
// result waits, and the sequencer pauses when it must emit into a full
// register that the receiver does not drain.
module sector_bitmap_allocator_core #(
  parameter int SECTORS   = sba_pkg::SECTORS_DEF,
  parameter int MAX_BATCH = sba_pkg::MAX_BATCH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  sba_pkg::in_t              in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output sba_pkg::out_t             out_data,
  input  logic                      cfg_we,
  input  logic [sba_pkg::CFG_W-1:0] cfg_wdata
);

  localparam int WB        = sba_pkg::WORD_BITS;
  localparam int MAP_WORDS = (SECTORS + WB - 1) / WB;
  localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int IW        = (AW + 6 > 17) ? AW + 6 : 17;
  localparam int CW        = sba_pkg::CNT_W;
  localparam int FW        = sba_pkg::TOTAL_W;
  localparam int SW        = sba_pkg::SECTOR_W;

  sba_pkg::state_t           state_r, state_nxt;
  logic [AW-1:0]             w_r, w_nxt;
  logic [WB-1:0]             word_r, word_nxt;
  logic [WB-1:0]             cand_r, cand_nxt;
  logic [CW-1:0]             n_r, n_nxt;
  logic [CW-1:0]             want_r, want_nxt;
  logic [SW-1:0]             sector_r, sector_nxt;
  logic                      rej_r, rej_nxt;
  logic                      pend_v_r, pend_v_nxt;
  logic [SW-1:0]             pend_sec_r, pend_sec_nxt;
  logic [FW-1:0]             pend_tot_r, pend_tot_nxt;
  logic [FW-1:0]             fc_r, fc_nxt;
  logic [sba_pkg::CFG_W-1:0] siu_r;
  logic                      out_valid_r;
  sba_pkg::out_t             out_data_r;

  logic                      ram_we, ram_re;
  logic [AW-1:0]             ram_waddr, ram_raddr;
  logic [WB-1:0]             ram_wdata, ram_rdata;
  sba_pkg::ff_t              ff;

  logic                      push;
  sba_pkg::out_t             push_data;
  logic                      out_free;
  logic [IW-1:0]             cap_i, base_i, limit_i;
  logic [WB-1:0]             range_mask, cand_now, rel_bit;
  logic                      next_in;
  logic [CW-1:0]             want_in;
  logic [FW-1:0]             fc_dec;

  // Bitmap memory and the lowest-set-bit search unit.
  sba_map_ram #(
    .DEPTH(MAP_WORDS),
    .AW   (AW)
  ) u_map (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  sba_find_first u_ff (
    .word(cand_r),
    .res (ff)
  );

  // Capacity is the register clamped to the map size.
  assign cap_i = (IW'(siu_r) > IW'(SECTORS)) ? IW'(SECTORS) : IW'(siu_r);

  // Range of the current word against the capacity.
  assign base_i     = IW'(w_r) << 5;
  assign limit_i    = cap_i - base_i;
  assign range_mask = (limit_i >= IW'(WB)) ? {WB{1'b1}} : ~({WB{1'b1}} << limit_i[4:0]);
  assign next_in    = (base_i + IW'(WB)) < cap_i;
  assign cand_now   = ram_rdata & range_mask;
  assign rel_bit    = WB'(1) << sector_r[4:0];

  assign want_in  = (in_data.count > CW'(MAX_BATCH)) ? CW'(MAX_BATCH) : in_data.count;
  assign fc_dec   = (fc_r != '0) ? fc_r - FW'(1) : fc_r;
  assign out_free = !out_valid_r || out_ready;

  // Sequencer: next state, memory control and result pushes.
  always_comb begin
    state_nxt    = state_r;
    w_nxt        = w_r;
    word_nxt     = word_r;
    cand_nxt     = cand_r;
    n_nxt        = n_r;
    want_nxt     = want_r;
    sector_nxt   = sector_r;
    rej_nxt      = rej_r;
    pend_v_nxt   = pend_v_r;
    pend_sec_nxt = pend_sec_r;
    pend_tot_nxt = pend_tot_r;
    fc_nxt       = fc_r;
    ram_we       = 1'b0;
    ram_waddr    = w_r;
    ram_wdata    = word_r;
    ram_re       = 1'b0;
    ram_raddr    = w_r;
    push         = 1'b0;
    push_data    = '0;
    in_ready     = 1'b0;
    case (state_r)
      sba_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_wdata = '0;
        if (w_r == AW'(MAP_WORDS - 1)) begin
          w_nxt     = '0;
          state_nxt = sba_pkg::ST_IDLE;
        end else begin
          w_nxt = w_r + AW'(1);
        end
      end
      sba_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          pend_v_nxt = 1'b0;
          n_nxt      = '0;
          rej_nxt    = 1'b0;
          sector_nxt = in_data.sector;
          want_nxt   = want_in;
          w_nxt      = '0;
          if (in_data.op == sba_pkg::OP_RELEASE) begin
            if (IW'(in_data.sector) >= cap_i) begin
              rej_nxt   = 1'b1;
              state_nxt = sba_pkg::ST_FINAL;
            end else begin
              ram_re    = 1'b1;
              ram_raddr = AW'(in_data.sector >> 5);
              w_nxt     = AW'(in_data.sector >> 5);
              state_nxt = sba_pkg::ST_RUPD;
            end
          end else if (want_in == '0 || cap_i == '0) begin
            state_nxt = sba_pkg::ST_FINAL;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = '0;
            state_nxt = sba_pkg::ST_ALOAD;
          end
        end
      end
      sba_pkg::ST_RUPD: begin
        // Set the bit; count it only if it was clear.
        ram_we    = 1'b1;
        ram_wdata = ram_rdata | rel_bit;
        if ((ram_rdata & rel_bit) == '0) begin
          fc_nxt = fc_r + FW'(1);
        end
        state_nxt = sba_pkg::ST_FINAL;
      end
      sba_pkg::ST_ALOAD: begin
        // Words without a free sector in range are skipped at one per cycle.
        word_nxt = ram_rdata;
        cand_nxt = cand_now;
        if (cand_now != '0) begin
          state_nxt = sba_pkg::ST_AGRANT;
        end else if (next_in) begin
          ram_re    = 1'b1;
          ram_raddr = w_r + AW'(1);
          w_nxt     = w_r + AW'(1);
        end else begin
          state_nxt = sba_pkg::ST_FINAL;
        end
      end
      sba_pkg::ST_AGRANT: begin
        // A grant is held in the pending register so the final one can carry last.
        if (!pend_v_r || out_free) begin
          if (pend_v_r) begin
            push                     = 1'b1;
            push_data.granted_sector = pend_sec_r;
            push_data.granted        = 1'b1;
            push_data.free_total     = pend_tot_r;
          end
          pend_v_nxt   = 1'b1;
          pend_sec_nxt = SW'(base_i + IW'(ff.idx));
          pend_tot_nxt = fc_dec;
          fc_nxt       = fc_dec;
          word_nxt     = word_r & ~ff.low;
          cand_nxt     = cand_r & ~ff.low;
          n_nxt        = n_r + CW'(1);
          if ((n_r + CW'(1) == want_r) || ((cand_r & ~ff.low) == '0)) begin
            state_nxt = sba_pkg::ST_AWB;
          end
        end
      end
      sba_pkg::ST_AWB: begin
        // Write the word back, fetching the next one if more are wanted and in range.
        ram_we = 1'b1;
        if (n_r == want_r || !next_in) begin
          state_nxt = sba_pkg::ST_FINAL;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = w_r + AW'(1);
          w_nxt     = w_r + AW'(1);
          state_nxt = sba_pkg::ST_ALOAD;
        end
      end
      sba_pkg::ST_FINAL: begin
        if (out_free) begin
          push           = 1'b1;
          push_data.last = 1'b1;
          if (pend_v_r) begin
            push_data.granted_sector = pend_sec_r;
            push_data.granted        = 1'b1;
            push_data.free_total     = pend_tot_r;
          end else begin
            push_data.rejected   = rej_r;
            push_data.free_total = fc_r;
          end
          pend_v_nxt = 1'b0;
          state_nxt  = sba_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = sba_pkg::ST_IDLE;
      end
    endcase
  end

  // State register and control counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= sba_pkg::ST_CLEAR;
      w_r      <= '0;
      n_r      <= '0;
      pend_v_r <= 1'b0;
      fc_r     <= '0;
    end else begin
      state_r  <= state_nxt;
      w_r      <= w_nxt;
      n_r      <= n_nxt;
      pend_v_r <= pend_v_nxt;
      fc_r     <= fc_nxt;
    end
  end

  // Working payload registers.
  always_ff @(posedge clk) begin
    word_r     <= word_nxt;
    cand_r     <= cand_nxt;
    want_r     <= want_nxt;
    sector_r   <= sector_nxt;
    rej_r      <= rej_nxt;
    pend_sec_r <= pend_sec_nxt;
    pend_tot_r <= pend_tot_nxt;
  end

  // Capacity register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      siu_r <= sba_pkg::SIU_RESET;
    end else if (cfg_we) begin
      siu_r <= cfg_wdata;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (push) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_data_r <= push_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A push never overwrites a result that is still waiting.
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> out_free)
    else $error("result pushed into a full output register");

  // The grant count never passes the request.
  a_batch_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sba_pkg::ST_AGRANT || state_r == sba_pkg::ST_AWB) |-> n_r <= want_r)
    else $error("more sectors granted than requested");

  // The grant state is only entered with a candidate bit in hand.
  a_grant_cand: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sba_pkg::ST_AGRANT) |-> cand_r != '0)
    else $error("grant state without a free candidate");

  // A granted result is never flagged as rejected.
  a_grant_not_rej: assert property (@(posedge clk) disable iff (!rst_n)
    push && push_data.granted |-> !push_data.rejected)
    else $error("granted result also marked rejected");

  // A held grant exists only during an allocation.
  a_pend_scope: assert property (@(posedge clk) disable iff (!rst_n)
    pend_v_r |-> (state_r == sba_pkg::ST_AGRANT || state_r == sba_pkg::ST_AWB ||
                  state_r == sba_pkg::ST_ALOAD || state_r == sba_pkg::ST_FINAL))
    else $error("held grant outside an allocation");

endmodule
